/* design/aft_pkg.sv */
// ----------------------------------------------------------------------------
// aft_pkg
// Shared constants for the fitted ACES tone-mapping pipeline: field widths,
// fixed-point formats, curve constants and the two color matrices.
// ----------------------------------------------------------------------------
package aft_pkg;

  localparam int IN_W          = 24;  // input channel width
  localparam int IN_FRAC_DEF   = 16;
  localparam int OUT_FRAC_DEF  = 16;

  localparam int V_FRAC        = 20;  // curve argument is Q.20
  localparam int V_W           = 29;  // 0 .. 256.0 in Q.20
  localparam logic [V_W-1:0] V_MAX = V_W'(256) << V_FRAC;

  localparam int PRD_W         = 48;  // input matrix product
  localparam int SUM_W         = 51;  // input matrix row sum plus rounding
  localparam int NUM_W         = 58;  // |a| in Q.40
  localparam int DEN_W         = 58;  // b in Q.40
  localparam int FIT_FRAC      = 24;
  localparam int Q_W           = FIT_FRAC + 1;  // quotient below 2.0
  localparam int FIT_W         = Q_W + 1;       // signed fit
  localparam int OPRD_W        = 52;  // output matrix product
  localparam int OSUM_W        = 54;  // output matrix row sum

  localparam logic [23:0] K_LIN_Q20  = 24'd25773;
  localparam logic [38:0] K_OFS_Q40  = 39'd99546484;
  localparam logic [23:0] K_SQ_Q24   = 24'd16504234;
  localparam logic [23:0] K_MID_Q20  = 24'd453982;
  localparam logic [38:0] K_BASE_Q40 = 39'd261772827853;

  // unsigned Q.24 coefficients
  localparam logic [23:0] MAT_IN [3][3] = '{
    '{24'd10019186, 24'd5948865,  24'd809165},
    '{24'd1275068,  24'd15239416, 24'd262731},
    '{24'd476473,   24'd2245295,  24'd14055448}
  };

  localparam logic signed [25:0] MAT_OUT [3][3] = '{
    '{ 26'sd26923237, -26'sd8910044,  -26'sd1235978},
    '{-26'sd1712618,   26'sd18591336, -26'sd101502},
    '{-26'sd54861,    -26'sd1220710,   26'sd18052620}
  };

endpackage

/* design/aft_if.sv */
// ----------------------------------------------------------------------------
// aft_if
// Valid/ready channels for the tone-mapping block: linear input pixel word
// and tone-mapped output pixel word.
// ----------------------------------------------------------------------------
interface aft_pix_in_if;
  logic                    valid;
  logic                    ready;
  logic [aft_pkg::IN_W-1:0] red_in;
  logic [aft_pkg::IN_W-1:0] green_in;
  logic [aft_pkg::IN_W-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface aft_pix_out_if #(
  parameter int W = aft_pkg::OUT_FRAC_DEF + 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] red_out;
  logic [W-1:0] green_out;
  logic [W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

/* design/aft_mat_in.sv */
// ----------------------------------------------------------------------------
// aft_mat_in
// Input color matrix: products in one stage, row sums rounded to Q.20 and
// saturated at 256.0 in the next.
// ----------------------------------------------------------------------------
module aft_mat_in #(
  parameter int IN_FRAC_BITS = aft_pkg::IN_FRAC_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [aft_pkg::IN_W-1:0]  x_i [3],
  output logic                      valid_o,
  output logic [aft_pkg::V_W-1:0]   v_o [3]
);
  import aft_pkg::*;

  localparam int SH = IN_FRAC_BITS + 24 - V_FRAC;
  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (SH - 1);

  logic             vld1_q, vld2_q;
  logic [PRD_W-1:0] prd_q [3][3];
  logic [V_W-1:0]   v_d [3];
  logic [V_W-1:0]   v_q [3];

  always_comb begin
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] sh;
    for (int r = 0; r < 3; r++) begin
      s = SUM_W'(prd_q[r][0]) + SUM_W'(prd_q[r][1]) + SUM_W'(prd_q[r][2]) + RND;
      sh = s >> SH;
      v_d[r] = (sh > SUM_W'(V_MAX)) ? V_MAX : sh[V_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prd_q[r][c] <= MAT_IN[r][c] * x_i[c];
        end
        v_q[r] <= v_d[r];
      end
    end
  end

  assign valid_o = vld2_q;
  assign v_o     = v_q;

endmodule

/* design/aft_curve.sv */
// ----------------------------------------------------------------------------
// aft_curve
// Rational fit a/b for one channel: three stages build a and b in Q.40, a
// restoring divider gives one quotient bit per stage, a last stage signs it.
// ----------------------------------------------------------------------------
module aft_curve (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic                                valid_i,
  input  logic [aft_pkg::V_W-1:0]             v_i,
  output logic                                valid_o,
  output logic signed [aft_pkg::FIT_W-1:0]    fit_o
);
  import aft_pkg::*;

  localparam int NQ = Q_W;  // divider stages

  // stage A
  logic             vld_a_q;
  logic [NUM_W-1:0] pv_q;
  logic [52:0]      ts_q;
  logic [V_W-1:0]   va_q;
  // stage B
  logic             vld_b_q;
  logic [NUM_W-1:0] nb_q;
  logic             sgb_q;
  logic [V_W-1:0]   tm_q;
  logic [V_W-1:0]   vb_q;
  // stage C
  logic             vld_c_q;
  logic [NUM_W-1:0] nc_q;
  logic             sgc_q;
  logic [DEN_W-1:0] den_q;
  // divider
  logic             vld_dv_q [NQ];
  logic [DEN_W-1:0] rem_q [NQ];
  logic [DEN_W-1:0] dd_q  [NQ];
  logic [Q_W-1:0]   qt_q  [NQ];
  logic             sg_q  [NQ];
  logic [DEN_W-1:0] rem_d [NQ];
  logic [Q_W-1:0]   qt_d  [NQ];
  // output
  logic                    vld_o_q;
  logic signed [FIT_W-1:0] fit_q;

  logic signed [NUM_W:0] num;
  logic [NUM_W:0]        mag;
  logic [53:0]           t_rnd;
  logic [V_W-1:0]        t;

  always_comb begin
    num   = $signed({1'b0, pv_q}) - $signed((NUM_W+1)'(K_OFS_Q40));
    mag   = num[NUM_W] ? (NUM_W+1)'(-num) : num;
    t_rnd = 54'(ts_q) + (54'(1) << 23);
    t     = t_rnd[24 +: V_W];
  end

  // first quotient bit is the integer part (a/b stays below 2)
  always_comb begin
    logic [DEN_W:0] r2;
    logic           ge;
    ge       = nc_q >= den_q;
    rem_d[0] = ge ? (nc_q - den_q) : nc_q;
    qt_d[0]  = Q_W'(ge);
    for (int j = 1; j < NQ; j++) begin
      r2       = {rem_q[j-1], 1'b0};
      ge       = r2 >= {1'b0, dd_q[j-1]};
      rem_d[j] = ge ? DEN_W'(r2 - {1'b0, dd_q[j-1]}) : r2[DEN_W-1:0];
      qt_d[j]  = {qt_q[j-1][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
      vld_c_q <= 1'b0;
      vld_o_q <= 1'b0;
      for (int j = 0; j < NQ; j++) vld_dv_q[j] <= 1'b0;
    end else if (en_i) begin
      vld_a_q     <= valid_i;
      vld_b_q     <= vld_a_q;
      vld_c_q     <= vld_b_q;
      vld_dv_q[0] <= vld_c_q;
      for (int j = 1; j < NQ; j++) vld_dv_q[j] <= vld_dv_q[j-1];
      vld_o_q     <= vld_dv_q[NQ-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pv_q  <= NUM_W'(v_i * (v_i + V_W'(K_LIN_Q20)));
      ts_q  <= K_SQ_Q24 * v_i;
      va_q  <= v_i;
      nb_q  <= mag[NUM_W-1:0];
      sgb_q <= num[NUM_W];
      tm_q  <= t + V_W'(K_MID_Q20);
      vb_q  <= va_q;
      nc_q  <= nb_q;
      sgc_q <= sgb_q;
      den_q <= DEN_W'(tm_q * vb_q) + DEN_W'(K_BASE_Q40);
      rem_q[0] <= rem_d[0];
      qt_q[0]  <= qt_d[0];
      dd_q[0]  <= den_q;
      sg_q[0]  <= sgc_q;
      for (int j = 1; j < NQ; j++) begin
        rem_q[j] <= rem_d[j];
        qt_q[j]  <= qt_d[j];
        dd_q[j]  <= dd_q[j-1];
        sg_q[j]  <= sg_q[j-1];
      end
      fit_q <= sg_q[NQ-1] ? -$signed({1'b0, qt_q[NQ-1]}) : $signed({1'b0, qt_q[NQ-1]});
    end
  end

  assign valid_o = vld_o_q;
  assign fit_o   = fit_q;

endmodule

/* design/aft_mat_out.sv */
// ----------------------------------------------------------------------------
// aft_mat_out
// Output color matrix on the signed fits, then round to the output fraction
// and clamp to [0, 1].
// ----------------------------------------------------------------------------
module aft_mat_out #(
  parameter int OUT_FRAC_BITS = aft_pkg::OUT_FRAC_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [aft_pkg::FIT_W-1:0]  fit_i [3],
  output logic                              valid_o,
  output logic [OUT_FRAC_BITS:0]            o_o [3]
);
  import aft_pkg::*;

  localparam int OW = OUT_FRAC_BITS + 1;
  localparam int SH = 48 - OUT_FRAC_BITS;
  localparam logic [OSUM_W-1:0] RND = OSUM_W'(1) << (SH - 1);
  localparam logic [OSUM_W-1:0] ONE = OSUM_W'(1) << OUT_FRAC_BITS;

  logic                     vld1_q, vld2_q;
  logic signed [OPRD_W-1:0] prd_q [3][3];
  logic [OW-1:0]            o_d [3];
  logic [OW-1:0]            o_q [3];

  always_comb begin
    logic signed [OSUM_W-1:0] s;
    logic [OSUM_W-1:0]        r;
    for (int k = 0; k < 3; k++) begin
      s = OSUM_W'(prd_q[k][0]) + OSUM_W'(prd_q[k][1]) + OSUM_W'(prd_q[k][2]);
      r = (OSUM_W'(s) + RND) >> SH;
      if (s <= 0) begin
        o_d[k] = '0;
      end else if (r > ONE) begin
        o_d[k] = ONE[OW-1:0];
      end else begin
        o_d[k] = r[OW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        for (int c = 0; c < 3; c++) begin
          prd_q[k][c] <= OPRD_W'(MAT_OUT[k][c] * fit_i[c]);
        end
        o_q[k] <= o_d[k];
      end
    end
  end

  assign valid_o = vld2_q;
  assign o_o     = o_q;

endmodule

/* design/aces_fitted_tonemap.sv */
// ----------------------------------------------------------------------------
// aces_fitted_tonemap
// Fitted ACES tone curve with input and output color matrices, one pixel a
// clock while pix_o.ready stays high.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i takes a linear RGB word, unsigned with IN_FRAC_BITS fraction bits.
//   pix_o gives the tone-mapped word, 0 .. 1.0 with OUT_FRAC_BITS fraction
//   bits (1.0 = 1 << OUT_FRAC_BITS).
//   Throughput: one word per cycle, with no bubbles while pix_o.ready is high.
//   Pipeline from accept to valid on pix_o: 2 input matrix stages,
//   3 curve polynomial stages, 25 divider stages (one quotient bit each),
//   1 sign stage, 2 output matrix stages and the output register.
//   All stages move together on one enable; a skid register behind the
//   output register takes the word in flight when the receiver stalls, and
//   pix_i.ready drops only while the skid register is full.
//   Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module aces_fitted_tonemap #(
  parameter int IN_FRAC_BITS  = aft_pkg::IN_FRAC_DEF,
  parameter int OUT_FRAC_BITS = aft_pkg::OUT_FRAC_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  aft_pix_in_if.sink    pix_i,
  aft_pix_out_if.source pix_o
);
  import aft_pkg::*;

  localparam int OW = OUT_FRAC_BITS + 1;

  logic                    en;
  logic [IN_W-1:0]         x [3];
  logic                    vld_v, vld_f, vld_m;
  logic [V_W-1:0]          v [3];
  logic                    vld_fc [3];
  logic signed [FIT_W-1:0] fit [3];
  logic [OW-1:0]           m [3];

  logic          out_vld_q, sk_vld_q;
  logic [OW-1:0] out_q [3];
  logic [OW-1:0] sk_q  [3];

  assign en          = !sk_vld_q;
  assign pix_i.ready = en;
  assign x[0] = pix_i.red_in;
  assign x[1] = pix_i.green_in;
  assign x[2] = pix_i.blue_in;

  aft_mat_in #(.IN_FRAC_BITS(IN_FRAC_BITS)) u_mat_in (
    .clk_i, .rst_ni, .en_i(en), .valid_i(pix_i.valid), .x_i(x),
    .valid_o(vld_v), .v_o(v)
  );

  for (genvar g = 0; g < 3; g++) begin : g_curve
    aft_curve u_curve (
      .clk_i, .rst_ni, .en_i(en), .valid_i(vld_v), .v_i(v[g]),
      .valid_o(vld_fc[g]), .fit_o(fit[g])
    );
  end
  assign vld_f = vld_fc[0];

  aft_mat_out #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_mat_out (
    .clk_i, .rst_ni, .en_i(en), .valid_i(vld_f), .fit_i(fit),
    .valid_o(vld_m), .o_o(m)
  );

  // output register plus skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      sk_vld_q  <= 1'b0;
    end else if (sk_vld_q) begin
      if (pix_o.ready) begin
        sk_vld_q <= 1'b0;
      end
    end else if (vld_m) begin
      if (out_vld_q && !pix_o.ready) begin
        sk_vld_q <= 1'b1;
      end else begin
        out_vld_q <= 1'b1;
      end
    end else if (pix_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_vld_q) begin
      if (pix_o.ready) out_q <= sk_q;
    end else if (vld_m) begin
      if (out_vld_q && !pix_o.ready) sk_q <= m;
      else                           out_q <= m;
    end
  end

  assign pix_o.valid     = out_vld_q;
  assign pix_o.red_out   = out_q[0];
  assign pix_o.green_out = out_q[1];
  assign pix_o.blue_out  = out_q[2];

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_vld_q |-> out_vld_q) else $error("skid word without output word");

  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sk_vld_q) |-> $past(out_vld_q && !pix_o.ready))
    else $error("skid filled without a stall");

  a_curve_vld_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_fc[0] == vld_fc[1]) && (vld_fc[0] == vld_fc[2]))
    else $error("curve lanes out of step");

  a_out_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q[0] <= (OW'(1) << OUT_FRAC_BITS))
                  && (out_q[1] <= (OW'(1) << OUT_FRAC_BITS))
                  && (out_q[2] <= (OW'(1) << OUT_FRAC_BITS)))
    else $error("output above 1.0");

endmodule
